FILE: design/fslp_pkg.sv
// ============================================================================
// fslp_pkg
// Shared types, character codes and result codes of the script line parser.
// ============================================================================
package fslp_pkg;

    // Sequencer states of the parser.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TAKE,
        ST_CLOSE,
        ST_RD,
        ST_BYTE,
        ST_EOS,
        ST_WAIT
    } t_state;

    // Position within the current script line.
    typedef enum logic [2:0] {
        PH_START,
        PH_SKIP,
        PH_COLON,
        PH_HEX,
        PH_DELAY
    } t_phase;

    // Result kinds.
    localparam logic [2:0] KIND_WRITE   = 3'd0;
    localparam logic [2:0] KIND_COMPARE = 3'd1;
    localparam logic [2:0] KIND_DELAY   = 3'd2;
    localparam logic [2:0] KIND_ERROR   = 3'd3;
    localparam logic [2:0] KIND_DONE    = 3'd4;

    // Line kinds as latched from the line's first letter.
    localparam logic [1:0] LK_WRITE   = 2'd0;
    localparam logic [1:0] LK_COMPARE = 2'd1;
    localparam logic [1:0] LK_DELAY   = 2'd2;

    // Character codes.
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_W     = 8'h57;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_X     = 8'h58;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;

    // Only this many characters after the colon of a delay line count.
    localparam logic [3:0] MAX_DELAY_DIGITS = 4'd15;

    localparam logic [15:0] OFFSET_MAX = 16'hFFFF;

    // Hex digit decode: bit 4 is set for a valid digit, bits 3:0 hold its value.
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] res;
        res = 5'd0;
        if (c inside {[CH_0 : CH_9]}) begin
            res = {1'b1, 4'(c - CH_0)};
        end else if (c inside {[CH_UA : CH_UF]}) begin
            res = {1'b1, 4'(c - CH_UA + 8'd10)};
        end else if (c inside {[CH_LA : CH_LF]}) begin
            res = {1'b1, 4'(c - CH_LA + 8'd10)};
        end
        return res;
    endfunction

endpackage

FILE: design/fslp_ram.sv
// ============================================================================
// fslp_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module fslp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: design/flash_script_line_parser_top.sv
// ============================================================================
// flash_script_line_parser_top
// Parses a register script one character per item and emits write, compare,
// delay, error and stream done result items.
// ============================================================================
//
//  channel  direction  handshake           payload
//  -------  ---------  ------------------  ------------------------------------
//  input    in         i_valid / o_stall   i_char_code, i_end_of_stream
//  output   out        o_valid / i_stall   o_kind, o_register_addr, o_data_byte,
//                                          o_byte_index, o_delay_ms,
//                                          o_error_offset, o_last
//
//  A character without results is accepted, then takes one parse step.
//  Each result item adds a wait state plus output stall time. A line close
//  adds a close step and an end step. Data bytes are read back from the
//  line buffer RAM one at a time, each with a read step, a byte step and
//  its wait state. Stream end adds the close step unless the stream has
//  failed, an end step and the done item's wait state.
//  o_stall is high whenever the sequencer is not idle; one item is in work.
//  Reset is synchronous and active low; no clearing pass is needed.
//
module flash_script_line_parser_top
    import fslp_pkg::*;
#(
    parameter int MAX_DATA_BYTES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_char_code,
    input  logic        i_end_of_stream,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_kind,
    output logic [7:0]  o_register_addr,
    output logic [7:0]  o_data_byte,
    output logic [4:0]  o_byte_index,
    output logic [15:0] o_delay_ms,
    output logic [15:0] o_error_offset,
    output logic        o_last
);

    localparam int CW = $clog2(MAX_DATA_BYTES + 3);
    localparam int AW = (MAX_DATA_BYTES > 1) ? $clog2(MAX_DATA_BYTES) : 1;
    localparam logic [CW-1:0] CNT_FULL = CW'(MAX_DATA_BYTES + 2);

    // Sequencer and captured input item.
    t_state r_state, n_state;
    t_state r_ret, n_ret;
    logic [7:0] r_char;
    logic       r_eos;

    // Parse state.
    t_phase        r_phase, n_phase;
    logic [CW-1:0] r_count, n_count;
    logic [7:0]    r_target, n_target;
    logic [1:0]    r_line_kind, n_line_kind;
    logic [4:0]    r_nib, n_nib;
    logic [15:0]   r_delay, n_delay;
    logic [3:0]    r_digits, n_digits;
    logic [15:0]   r_char_off, n_char_off;
    logic [15:0]   r_line_off, n_line_off;
    logic          r_failed, n_failed;
    logic [CW-1:0] r_idx, n_idx;

    // Output register.
    logic        r_valid, n_valid;
    logic [2:0]  r_kind, n_kind;
    logic [7:0]  r_reg, n_reg;
    logic [7:0]  r_data, n_data;
    logic [4:0]  r_bidx, n_bidx;
    logic [15:0] r_dly, n_dly;
    logic [15:0] r_err, n_err;
    logic        r_last, n_last;

    // Line buffer port signals.
    logic          w_wr_en;
    logic [CW-1:0] w_wr_full;
    logic [7:0]    w_wr_data;
    logic [7:0]    w_rd_data;

    // Emission request from the sequencer.
    logic        e_emit;
    logic [2:0]  e_kind;
    logic [7:0]  e_reg;
    logic [7:0]  e_data;
    logic [4:0]  e_bidx;
    logic [15:0] e_dly;
    logic [15:0] e_err;
    logic        e_last;

    // Parse helpers.
    logic [4:0]  w_hex;
    logic [19:0] w_mac;
    logic        w_fail;
    logic        w_close;

    fslp_ram #(
        .WIDTH (8),
        .DEPTH (MAX_DATA_BYTES)
    ) u_line_buf (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_full[AW-1:0]),
        .i_wr_data (w_wr_data),
        .i_rd_addr (r_idx[AW-1:0]),
        .o_rd_data (w_rd_data)
    );

    assign o_stall         = (r_state != ST_IDLE);
    assign o_valid         = r_valid;
    assign o_kind          = r_kind;
    assign o_register_addr = r_reg;
    assign o_data_byte     = r_data;
    assign o_byte_index    = r_bidx;
    assign o_delay_ms      = r_dly;
    assign o_error_offset  = r_err;
    assign o_last          = r_last;

    // Shared decode and multiply-by-ten accumulate unit.
    assign w_hex     = hex_decode(r_char);
    assign w_mac     = (20'(r_delay) << 3) + (20'(r_delay) << 1) + 20'(w_hex[3:0]);
    assign w_wr_full = r_count - CW'(2);
    assign w_wr_data = {r_nib[3:0], w_hex[3:0]};

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ret       <= ST_IDLE;
            r_phase     <= PH_START;
            r_count     <= '0;
            r_target    <= '0;
            r_line_kind <= LK_WRITE;
            r_nib       <= '0;
            r_delay     <= '0;
            r_digits    <= '0;
            r_char_off  <= '0;
            r_line_off  <= '0;
            r_failed    <= 1'b0;
            r_idx       <= '0;
            r_valid     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ret       <= n_ret;
            r_phase     <= n_phase;
            r_count     <= n_count;
            r_target    <= n_target;
            r_line_kind <= n_line_kind;
            r_nib       <= n_nib;
            r_delay     <= n_delay;
            r_digits    <= n_digits;
            r_char_off  <= n_char_off;
            r_line_off  <= n_line_off;
            r_failed    <= n_failed;
            r_idx       <= n_idx;
            r_valid     <= n_valid;
        end
    end

    // Captured item and output payload.
    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_char <= i_char_code;
            r_eos  <= i_end_of_stream;
        end
        r_kind <= n_kind;
        r_reg  <= n_reg;
        r_data <= n_data;
        r_bidx <= n_bidx;
        r_dly  <= n_dly;
        r_err  <= n_err;
        r_last <= n_last;
    end

    // Sequencer: next state, parse update and result emission.
    always_comb begin
        n_state     = r_state;
        n_ret       = r_ret;
        n_phase     = r_phase;
        n_count     = r_count;
        n_target    = r_target;
        n_line_kind = r_line_kind;
        n_nib       = r_nib;
        n_delay     = r_delay;
        n_digits    = r_digits;
        n_char_off  = r_char_off;
        n_line_off  = r_line_off;
        n_failed    = r_failed;
        n_idx       = r_idx;
        n_valid     = r_valid;
        n_kind      = r_kind;
        n_reg       = r_reg;
        n_data      = r_data;
        n_bidx      = r_bidx;
        n_dly       = r_dly;
        n_err       = r_err;
        n_last      = r_last;
        w_wr_en     = 1'b0;
        w_fail      = 1'b0;
        w_close     = 1'b0;
        e_emit      = 1'b0;
        e_kind      = KIND_WRITE;
        e_reg       = '0;
        e_data      = '0;
        e_bidx      = '0;
        e_dly       = '0;
        e_err       = '0;
        e_last      = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_TAKE;
                end
            end

            // One parse step on the captured character.
            ST_TAKE: begin
                if (r_char != CH_SPACE && !r_failed) begin
                    if (r_phase == PH_START) begin
                        n_line_off = r_char_off;
                    end
                    if (r_char_off != OFFSET_MAX) begin
                        n_char_off = r_char_off + 16'd1;
                    end
                    case (r_phase)
                        PH_START: begin
                            if (r_char == CH_SEMI) begin
                                n_phase = PH_SKIP;
                            end else if (r_char == CH_W) begin
                                n_line_kind = LK_WRITE;
                                n_phase     = PH_COLON;
                            end else if (r_char == CH_C) begin
                                n_line_kind = LK_COMPARE;
                                n_phase     = PH_COLON;
                            end else if (r_char == CH_X) begin
                                n_line_kind = LK_DELAY;
                                n_phase     = PH_COLON;
                            end else begin
                                w_fail = 1'b1;
                            end
                        end
                        PH_SKIP: begin
                            if (r_char == CH_NL) begin
                                n_phase = PH_START;
                            end
                        end
                        PH_COLON: begin
                            if (r_char == CH_COLON) begin
                                n_count  = '0;
                                n_nib    = '0;
                                n_delay  = '0;
                                n_digits = '0;
                                n_phase  = (r_line_kind == LK_DELAY) ? PH_DELAY : PH_HEX;
                            end else begin
                                w_fail = 1'b1;
                            end
                        end
                        PH_HEX: begin
                            if (r_char == CH_NL) begin
                                w_close = 1'b1;
                            end else if (r_count >= CNT_FULL) begin
                                // Full line: the rest is ignored.
                            end else if (!w_hex[4]) begin
                                w_fail = 1'b1;
                            end else if (!r_nib[4]) begin
                                n_nib = {1'b1, w_hex[3:0]};
                            end else begin
                                n_nib = '0;
                                if (r_count == CW'(1)) begin
                                    n_target = w_wr_data;
                                end else if (r_count >= CW'(2)) begin
                                    w_wr_en = 1'b1;
                                end
                                n_count = r_count + CW'(1);
                            end
                        end
                        PH_DELAY: begin
                            if (r_char == CH_NL) begin
                                w_close = 1'b1;
                            end else if (r_digits >= MAX_DELAY_DIGITS) begin
                                // Digit limit reached or parsing stopped.
                            end else if (r_char inside {[CH_0 : CH_9]}) begin
                                n_digits = r_digits + 4'd1;
                                n_delay  = (w_mac > 20'(OFFSET_MAX)) ? OFFSET_MAX
                                                                     : w_mac[15:0];
                            end else begin
                                n_digits = MAX_DELAY_DIGITS;
                            end
                        end
                        default: begin
                            n_phase = PH_START;
                        end
                    endcase
                end

                if (w_fail) begin
                    n_failed = 1'b1;
                    n_phase  = PH_START;
                    e_emit   = 1'b1;
                    e_kind   = KIND_ERROR;
                    e_err    = n_line_off;
                    e_last   = !r_eos;
                    n_state  = r_eos ? ST_EOS : ST_IDLE;
                end else if (w_close || (r_eos && !r_failed)) begin
                    n_state = ST_CLOSE;
                end else if (r_eos) begin
                    n_state = ST_EOS;
                end else begin
                    n_state = ST_IDLE;
                end
            end

            // Close the current line at newline or stream end.
            ST_CLOSE: begin
                n_phase = PH_START;
                n_state = ST_EOS;
                case (r_phase)
                    PH_COLON: begin
                        n_failed = 1'b1;
                        e_emit   = 1'b1;
                        e_kind   = KIND_ERROR;
                        e_err    = r_line_off;
                        e_last   = !r_eos;
                    end
                    PH_HEX: begin
                        if (r_nib[4] || r_count < CW'(3)) begin
                            n_failed = 1'b1;
                            e_emit   = 1'b1;
                            e_kind   = KIND_ERROR;
                            e_err    = r_line_off;
                            e_last   = !r_eos;
                        end else begin
                            n_idx   = '0;
                            n_state = ST_RD;
                        end
                    end
                    PH_DELAY: begin
                        e_emit = 1'b1;
                        e_kind = KIND_DELAY;
                        e_dly  = r_delay;
                        e_last = !r_eos;
                    end
                    default: begin
                        n_state = ST_EOS;
                    end
                endcase
            end

            // Line buffer read of the current data byte.
            ST_RD: begin
                n_state = ST_BYTE;
            end

            ST_BYTE: begin
                e_emit = 1'b1;
                e_kind = {1'b0, r_line_kind};
                e_reg  = r_target;
                e_data = w_rd_data;
                e_bidx = 5'(r_idx);
                if (r_idx == r_count - CW'(3)) begin
                    e_last  = !r_eos;
                    n_state = ST_EOS;
                end else begin
                    n_idx   = r_idx + CW'(1);
                    n_state = ST_RD;
                end
            end

            // End step: at stream end, done item and return to the reset parse state; else back to idle.
            ST_EOS: begin
                n_state = ST_IDLE;
                if (r_eos) begin
                    e_emit      = 1'b1;
                    e_kind      = KIND_DONE;
                    e_last      = 1'b1;
                    n_phase     = PH_START;
                    n_count     = '0;
                    n_target    = '0;
                    n_line_kind = LK_WRITE;
                    n_nib       = '0;
                    n_delay     = '0;
                    n_digits    = '0;
                    n_char_off  = '0;
                    n_line_off  = '0;
                    n_failed    = 1'b0;
                end
            end

            // Hold the result item until the output side takes it.
            ST_WAIT: begin
                if (!i_stall) begin
                    n_valid = 1'b0;
                    n_state = r_ret;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // Load the output register and park until it is taken.
        if (e_emit) begin
            n_valid = 1'b1;
            n_kind  = e_kind;
            n_reg   = e_reg;
            n_data  = e_data;
            n_bidx  = e_bidx;
            n_dly   = e_dly;
            n_err   = e_err;
            n_last  = e_last;
            n_ret   = n_state;
            n_state = ST_WAIT;
        end
    end

`ifndef ASSERT_OFF
    // A result item is only shown while the sequencer waits for it to be taken.
    a_valid_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_state == ST_WAIT))
        else $error("result item valid outside the wait state");

    // An accepted item always starts with a parse step.
    a_accept_to_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state == ST_TAKE))
        else $error("accepted item did not enter the parse step");

    // A stream done item is always the final result of its item.
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == KIND_DONE) |-> o_last)
        else $error("stream done item without last mark");

    // The byte counter never passes the full-line mark.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("byte counter beyond full line");
`endif

endmodule
